>>> rtl/core/ipv6p_pkg.sv
// ----------------------------------------------------------------------------
// ipv6p_pkg - shared types and constants of the IPv6 text address parser
// Character classes, the token passed from front to back, the result beat
// and the hex digit decode.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6p_pkg;

   localparam int unsigned GROUP_COUNT     = 8;
   localparam int unsigned GROUP_W         = 16;
   localparam int unsigned IDX_W           = $clog2(GROUP_COUNT);
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic [7:0] NUL_CHAR   = 8'h00;
   localparam logic [7:0] COLON_CHAR = 8'h3A;
   localparam logic [7:0] DIGIT_0    = 8'h30;
   localparam logic [7:0] DIGIT_9    = 8'h39;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_F    = 8'h66;
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] UPPER_F    = 8'h46;

   typedef enum logic [1:0] {
      KIND_DIGIT,
      KIND_SEP,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  nibble;
   } token_type;

   typedef struct packed {
      logic        addr_ok;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } result_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
      logic [7:0] diff;
      diff = 8'h00;
      if (ch >= DIGIT_0 && ch <= DIGIT_9) begin
         diff = ch - DIGIT_0;
      end else if (ch >= LOWER_A && ch <= LOWER_F) begin
         diff = ch - LOWER_A + 8'd10;
      end else if (ch >= UPPER_A && ch <= UPPER_F) begin
         diff = ch - UPPER_A + 8'd10;
      end
      return diff[3:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ipv6p_queue.sv
// ----------------------------------------------------------------------------
// ipv6p_queue - small register queue
// First-in first-out store of DEPTH beats; push and pop in the same cycle while neither full nor empty.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count not reduced by a lone pop");

   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count not raised by a lone push");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ipv6p_front.sv
// ----------------------------------------------------------------------------
// ipv6p_front - character intake and classification
// Sorts each character into digit, separator or end of string, decodes the
// hex nibble and queues the token for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_front #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic [7:0]           req_char_in,
   output logic                      req_full,
   input  wire logic                 tok_pop,
   output ipv6p_pkg::token_type      tok,
   output logic                      tok_empty
);

   import ipv6p_pkg::*;

   token_type tok_wr;

   always_comb begin
      tok_wr.nibble = hex_nibble(req_char_in);
      if (req_char_in == NUL_CHAR) begin
         tok_wr.kind = KIND_END;
      end else if (req_char_in == COLON_CHAR) begin
         tok_wr.kind = KIND_SEP;
      end else begin
         tok_wr.kind = KIND_DIGIT;
      end
   end

   ipv6p_queue #(
      .WIDTH ($bits(token_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_tok_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (tok_wr),
      .full    (req_full),
      .pop     (tok_pop),
      .rd_data (tok),
      .empty   (tok_empty)
   );

endmodule

`default_nettype wire

>>> rtl/core/ipv6p_back.sv
// ----------------------------------------------------------------------------
// ipv6p_back - group assembly and result output
// Shifts digits into the group accumulator, stores groups, forms the 128-bit
// address at the eighth group or end of string and queues the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_back #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ipv6p_pkg::token_type tok,
   input  wire logic                 tok_empty,
   output logic                      tok_pop,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output logic                      rsp_addr_ok,
   output logic [63:0]               rsp_addr_high,
   output logic [63:0]               rsp_addr_low
);

   import ipv6p_pkg::*;

   logic [GROUP_W-1:0] accum_ff, accum_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic [GROUP_W-1:0] store_ff [GROUP_COUNT];
   logic [GROUP_W-1:0] store_in [GROUP_COUNT];
   logic               skip_ff, skip_in;

   logic               res_full;
   logic               res_push;
   logic               tok_fire;
   logic               last;
   logic [GROUP_W-1:0] group [GROUP_COUNT];
   result_type         res_wr, res_rd;

   assign tok_pop  = !res_full;
   assign tok_fire = tok_pop && !tok_empty;
   assign last     = (index_ff == IDX_W'(GROUP_COUNT - 1));

   // current group merged in at its slot
   always_comb begin
      for (int k = 0; k < GROUP_COUNT; k++) begin
         group[k] = (index_ff == IDX_W'(k)) ? accum_ff : store_ff[k];
      end
      res_wr.addr_ok   = last;
      res_wr.addr_high = {group[0], group[1], group[2], group[3]};
      res_wr.addr_low  = {group[4], group[5], group[6], group[7]};
   end

   always_comb begin
      accum_in = accum_ff;
      index_in = index_ff;
      skip_in  = skip_ff;
      res_push = 1'b0;
      for (int k = 0; k < GROUP_COUNT; k++) begin
         store_in[k] = store_ff[k];
      end
      if (tok_fire) begin
         if (skip_ff) begin
            if (tok.kind == KIND_END) begin
               skip_in = 1'b0;
            end
         end else begin
            unique case (tok.kind) inside
               KIND_DIGIT: begin
                  accum_in = {accum_ff[GROUP_W-5:0], tok.nibble};
               end
               KIND_SEP, KIND_END: begin
                  accum_in = '0;
                  if (last || tok.kind == KIND_END) begin
                     res_push = 1'b1;
                     index_in = '0;
                     skip_in  = last && (tok.kind != KIND_END);
                     for (int k = 0; k < GROUP_COUNT; k++) begin
                        store_in[k] = '0;
                     end
                  end else begin
                     store_in[index_ff] = accum_ff;
                     index_in           = index_ff + 1'b1;
                  end
               end
               default: begin
                  accum_in = accum_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         index_ff <= '0;
         skip_ff  <= 1'b0;
         for (int k = 0; k < GROUP_COUNT; k++) begin
            store_ff[k] <= '0;
         end
      end else begin
         accum_ff <= accum_in;
         index_ff <= index_in;
         skip_ff  <= skip_in;
         for (int k = 0; k < GROUP_COUNT; k++) begin
            store_ff[k] <= store_in[k];
         end
      end
   end

   ipv6p_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_rd),
      .empty   (rsp_empty)
   );

   assign rsp_addr_ok   = res_rd.addr_ok;
   assign rsp_addr_high = res_rd.addr_high;
   assign rsp_addr_low  = res_rd.addr_low;

`ifndef SYNTHESIS
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      res_push |=> (index_ff == '0 && accum_ff == '0))
      else $error("string state not cleared after result beat");

   a_skip_idle: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (index_ff == '0 && accum_ff == '0))
      else $error("group state held while skipping trailing text");

   a_skip_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(skip_ff) |-> $past(res_push && res_wr.addr_ok))
      else $error("skip entered without a complete address");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ipv6_text_address_parser.sv
// ----------------------------------------------------------------------------
// ipv6_text_address_parser - full-form IPv6 text address parser
// Parses eight colon-separated hex groups, one character per beat.
//
// Input queue side: drive req_char_in and raise req_push; the beat is taken
// at a clock edge with req_full low. A character of zero ends the string.
// Result queue side: while rsp_empty is low the oldest result sits on
// rsp_addr_ok, rsp_addr_high and rsp_addr_low; rsp_pop takes it.
// A result is produced at the eighth group or at end of string.
// The closing character is registered in the token queue and its result in the
// result queue before the result shows on the rsp_ ports. Throughput: one
// character per cycle while req_full is low.
// A stalled receiver fills the result queue (QUEUE_DEPTH beats); the back
// end then stops taking tokens, the token queue fills and req_full rises.
// Reset clears both queues, the group store, accumulator and skip flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_text_address_parser #(
   parameter int unsigned QUEUE_DEPTH = ipv6p_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_char_in,
   output logic             req_full,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic             rsp_addr_ok,
   output logic [63:0]      rsp_addr_high,
   output logic [63:0]      rsp_addr_low
);

   import ipv6p_pkg::*;

   token_type tok;
   logic      tok_empty;
   logic      tok_pop;

   ipv6p_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_char_in (req_char_in),
      .req_full    (req_full),
      .tok_pop     (tok_pop),
      .tok         (tok),
      .tok_empty   (tok_empty)
   );

   ipv6p_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .tok           (tok),
      .tok_empty     (tok_empty),
      .tok_pop       (tok_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_addr_ok   (rsp_addr_ok),
      .rsp_addr_high (rsp_addr_high),
      .rsp_addr_low  (rsp_addr_low)
   );

endmodule

`default_nettype wire

>>> tb/sv/ipv6_text_address_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_test - testbench of the IPv6 text address parser
// Feeds characters one beat at a time through the push side and checks every
// popped address against a cycle-free predictor of the parser. Directed
// strings cover empty, short, long-group, non-hex and trailing-text cases;
// random strings follow, mostly well-formed, with random gaps and stalls.
// ----------------------------------------------------------------------------

module ipv6_text_address_parser_test;

   import ipv6p_pkg::*;

   localparam int unsigned ITEM_TARGET    = 850;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned DRAIN_CYCLES   = 8;

   typedef enum {
      STR_FULL,
      STR_TRAILING,
      STR_SHORT,
      STR_NOISE
   } string_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [7:0]  req_char_in = 8'h00;
   logic        req_full;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic        rsp_addr_ok;
   logic [63:0] rsp_addr_high;
   logic [63:0] rsp_addr_low;

   // predictor state
   logic [15:0] grp_accum;
   logic [2:0]  grp_count;
   logic [15:0] grp_store [GROUP_COUNT];
   bit          skipping;
   result_type  expected_addrs [$];

   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;
   int unsigned chars_sent;
   int unsigned strings_sent;
   int unsigned addrs_predicted;
   int unsigned addrs_checked;
   int unsigned ok_seen;
   int unsigned fail_count;
   int unsigned pop_hold;
   int unsigned idle_cycles;
   result_type  want;

   ipv6_text_address_parser u_top (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_char_in   (req_char_in),
      .req_full      (req_full),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_addr_ok   (rsp_addr_ok),
      .rsp_addr_high (rsp_addr_high),
      .rsp_addr_low  (rsp_addr_low)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [3:0] digit_value(input logic [7:0] ch);
      if (ch >= DIGIT_0 && ch <= DIGIT_9) begin
         return ch[3:0];
      end
      if ((ch >= LOWER_A && ch <= LOWER_F) || (ch >= UPPER_A && ch <= UPPER_F)) begin
         return ch[3:0] + 4'd9;
      end
      return 4'h0;
   endfunction

   function automatic int unsigned gap_len();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 70) begin
         return $urandom_range(1, 2);
      end else if (p < 95) begin
         return $urandom_range(3, 8);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char();
      int unsigned v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return DIGIT_0 + v[7:0];
      end
      return ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + v[7:0] - 8'd10;
   endfunction

   function automatic logic [7:0] noise_char();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 20) begin
         return COLON_CHAR;
      end else if (p < 25) begin
         return NUL_CHAR;
      end else if (p < 55) begin
         return hex_char();
      end
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic clear_groups();
      grp_accum = '0;
      grp_count = '0;
      foreach (grp_store[i]) begin
         grp_store[i] = '0;
      end
   endtask

   task automatic predict_address(input logic [7:0] ch);
      result_type r;
      logic       last;
      if (skipping) begin
         if (ch == NUL_CHAR) begin
            skipping = 1'b0;
            clear_groups();
         end
         return;
      end
      if (ch != NUL_CHAR && ch != COLON_CHAR) begin
         grp_accum = {grp_accum[11:0], digit_value(ch)};
         return;
      end
      grp_store[grp_count] = grp_accum;
      grp_accum = '0;
      last = (grp_count == 3'd7);
      if (last || ch == NUL_CHAR) begin
         r.addr_ok   = last;
         r.addr_high = {grp_store[0], grp_store[1], grp_store[2], grp_store[3]};
         r.addr_low  = {grp_store[4], grp_store[5], grp_store[6], grp_store[7]};
         expected_addrs.push_back(r);
         addrs_predicted++;
         clear_groups();
         skipping = last && (ch != NUL_CHAR);
      end else begin
         grp_count = grp_count + 3'd1;
      end
   endtask

   // one beat; returns at the edge that took it or, with gaps on, after a random gap
   task automatic send_char(input logic [7:0] ch);
      req_push    <= 1'b1;
      req_char_in <= ch;
      do begin
         @(posedge clock);
      end while (req_full);
      chars_sent++;
      predict_address(ch);
      if (gaps_on && $urandom_range(0, 99) < 25) begin
         req_push <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
      end
   endtask

   task automatic send_group(input int unsigned ndig);
      repeat (ndig) begin
         if ($urandom_range(0, 99) < 5) begin
            send_char(8'($urandom_range(8'h67, 8'h7A)));
         end else begin
            send_char(hex_char());
         end
      end
   endtask

   function automatic int unsigned digit_count();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 8) begin
         return 0;
      end else if (p < 88) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(5, 8);
   endfunction

   task automatic send_string(input string_kind_type kind);
      int unsigned n_groups;
      strings_sent++;
      case (kind) inside
         STR_FULL, STR_TRAILING: begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
               send_group(digit_count());
               if (g != GROUP_COUNT - 1) begin
                  send_char(COLON_CHAR);
               end
            end
            if (kind == STR_TRAILING) begin
               send_char(COLON_CHAR);
               repeat ($urandom_range(0, 6)) send_char(8'($urandom_range(1, 255)));
            end
            send_char(NUL_CHAR);
         end
         STR_SHORT: begin
            n_groups = $urandom_range(0, GROUP_COUNT - 1);
            for (int g = 0; g < n_groups; g++) begin
               send_group(digit_count());
               if (g != n_groups - 1) begin
                  send_char(COLON_CHAR);
               end
            end
            send_char(NUL_CHAR);
         end
         default: begin
            repeat ($urandom_range(1, 24)) send_char(noise_char());
            send_char(NUL_CHAR);
         end
      endcase
   endtask

   function automatic string_kind_type pick_kind();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 55) begin
         return STR_FULL;
      end else if (p < 70) begin
         return STR_TRAILING;
      end else if (p < 85) begin
         return STR_SHORT;
      end
      return STR_NOISE;
   endfunction

   task automatic wait_drained();
      while (expected_addrs.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // empty string, long group, non-hex bytes, leading and empty groups,
   // trailing text after the eighth group, eighth group closed by nul
   task automatic test_directed();
      send_char(NUL_CHAR);
      send_text("Ff90:aA");
      send_char(8'hFF);
      send_text("12345");
      send_char(8'h80);
      send_char(8'h7F);
      send_char(NUL_CHAR);
      send_text(":::::::aF:g");
      send_char(NUL_CHAR);
      send_text(":::::::");
      send_char(NUL_CHAR);
   endtask

   task automatic test_well_formed();
      repeat (6) send_string($urandom_range(0, 3) == 0 ? STR_TRAILING : STR_FULL);
   endtask

   task automatic test_back_to_back();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (3) send_string(pick_kind());
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // sender holds off until every address is out
   task automatic test_drain_pause();
      repeat (3) begin
         send_string(STR_FULL);
         req_push <= 1'b0;
         wait_drained();
      end
   endtask

   task automatic test_broken_strings();
      repeat (4) send_string(STR_SHORT);
      repeat (4) send_string(STR_NOISE);
   endtask

   task automatic test_random_mix();
      while (chars_sent < ITEM_TARGET) begin
         if (strings_sent % 8 == 0) begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
         end
         send_string(pick_kind());
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // result side: check each popped beat, then decide the next pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_addrs.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("unexpected address: ok=%0b high=%h low=%h",
                           rsp_addr_ok, rsp_addr_high, rsp_addr_low);
               end
            end else begin
               want = expected_addrs.pop_front();
               addrs_checked++;
               if (want.addr_ok) begin
                  ok_seen++;
               end
               if (rsp_addr_ok !== want.addr_ok || rsp_addr_high !== want.addr_high ||
                   rsp_addr_low !== want.addr_low) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("address %0d mismatch: exp ok=%0b high=%h low=%h",
                              addrs_checked, want.addr_ok, want.addr_high, want.addr_low);
                     $display("                      got ok=%0b high=%h low=%h",
                              rsp_addr_ok, rsp_addr_high, rsp_addr_low);
                  end
               end
            end
         end
         if (pop_hold != 0) begin
            pop_hold--;
            rsp_pop <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 99) < 20) begin
            pop_hold = gap_len() - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("** ipv6_text_address_parser: FAILED **");
         $finish;
      end
   end

   initial begin
      clear_groups();
      skipping = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_well_formed();
      test_back_to_back();
      test_drain_pause();
      test_broken_strings();
      test_random_mix();

      req_push <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_addrs.size() != 0) begin
         fail_count++;
         $display("%0d addresses never arrived", expected_addrs.size());
      end

      $display("%0d characters in %0d strings sent, with random gaps and stalls",
               chars_sent, strings_sent);
      $display("%0d addresses checked: %0d complete, %0d short or empty",
               addrs_checked, ok_seen, addrs_checked - ok_seen);
      if (fail_count == 0) begin
         $display("** ipv6_text_address_parser: PASSED **");
      end else begin
         $display("** ipv6_text_address_parser: FAILED **");
      end
      $finish;
   end

endmodule

>>> ipv6_text_address_parser.f
rtl/core/ipv6p_pkg.sv
rtl/core/ipv6p_queue.sv
rtl/core/ipv6p_front.sv
rtl/core/ipv6p_back.sv
rtl/core/ipv6_text_address_parser.sv
tb/sv/ipv6_text_address_parser_test.sv
